### rtl/core/pcmcv_pkg.sv
// Shared definitions for the PCM to signed 16-bit converter.
// Holds the format codes, G.711 constants and the stage-one payload type.
// No dependencies.
package pcmcv_pkg;

	localparam int FMT_W = 5;

	// Source format codes
	localparam logic [FMT_W-1:0] FMT_S32LE = 5'd0;
	localparam logic [FMT_W-1:0] FMT_S32BE = 5'd1;
	localparam logic [FMT_W-1:0] FMT_U32LE = 5'd2;
	localparam logic [FMT_W-1:0] FMT_U32BE = 5'd3;
	localparam logic [FMT_W-1:0] FMT_S24LE = 5'd4;
	localparam logic [FMT_W-1:0] FMT_S24BE = 5'd5;
	localparam logic [FMT_W-1:0] FMT_U24LE = 5'd6;
	localparam logic [FMT_W-1:0] FMT_U24BE = 5'd7;
	localparam logic [FMT_W-1:0] FMT_DAUD  = 5'd8;
	localparam logic [FMT_W-1:0] FMT_S16LE = 5'd9;
	localparam logic [FMT_W-1:0] FMT_S16BE = 5'd10;
	localparam logic [FMT_W-1:0] FMT_U16LE = 5'd11;
	localparam logic [FMT_W-1:0] FMT_U16BE = 5'd12;
	localparam logic [FMT_W-1:0] FMT_S8    = 5'd13;
	localparam logic [FMT_W-1:0] FMT_U8    = 5'd14;
	localparam logic [FMT_W-1:0] FMT_ALAW  = 5'd15;
	localparam logic [FMT_W-1:0] FMT_MULAW = 5'd16;

	localparam logic [FMT_W-1:0] FMT_RESET = FMT_S16LE;

	// G.711 and sign constants
	localparam logic [7:0]  ALAW_XOR   = 8'h55;
	localparam logic [7:0]  MULAW_BIAS = 8'h84;
	localparam logic [15:0] SIGN_FLIP  = 16'h8000;
	localparam logic [7:0]  U8_FLIP    = 8'h80;

	// Assembled sample handed from the byte assembler to the decoder
	typedef struct packed {
		logic [31:0]      word;
		logic [FMT_W-1:0] fmt;
		logic             last;
	} asm_word_t;

	// Bytes per sample for a format; zero for undefined codes
	function automatic logic [2:0] fmt_bytes(input logic [FMT_W-1:0] f);
		logic [2:0] n;
		if (f <= FMT_U32BE) begin
			n = 3'd4;
		end else if (f <= FMT_DAUD) begin
			n = 3'd3;
		end else if (f <= FMT_U16BE) begin
			n = 3'd2;
		end else if (f <= FMT_MULAW) begin
			n = 3'd1;
		end else begin
			n = 3'd0;
		end
		return n;
	endfunction

endpackage

### rtl/core/pcmcv_assemble.sv
// Byte assembler: collects stream bytes into one sample word per format.
// Registers the finished word into stage one. Depends on pcmcv_pkg.
module pcmcv_assemble import pcmcv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [FMT_W-1:0] fmt,
	input  logic             cfg_wr,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             in_end,
	input  logic             dec_ready,
	output logic             word_valid_s1,
	output asm_word_t        word_s1
);

	logic [23:0] held_q;
	logic [1:0]  pos_q;
	logic [2:0]  n_bytes;
	logic [2:0]  cnt;
	logic [31:0] word_next;
	logic        accept;
	logic        complete;

	assign n_bytes   = fmt_bytes(fmt);
	assign cnt       = {1'b0, pos_q} + 3'd1;
	assign word_next = {held_q, in_byte};
	assign in_ready  = !word_valid_s1 || dec_ready;
	assign accept    = in_valid && in_ready;
	assign complete  = (n_bytes != 3'd0) && (cnt >= n_bytes);

	// Track held bytes and the position within the current sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pos_q  <= '0;
		end else if (cfg_wr) begin
			held_q <= '0;
			pos_q  <= '0;
		end else if (accept) begin
			if (n_bytes == 3'd0 || complete || in_end) begin
				held_q <= '0;
				pos_q  <= '0;
			end else begin
				held_q <= word_next[23:0];
				pos_q  <= cnt[1:0];
			end
		end
	end

	// Stage one valid: set on a completed sample, drop when the decoder takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_s1 <= 1'b0;
		end else if (accept && complete) begin
			word_valid_s1 <= 1'b1;
		end else if (dec_ready) begin
			word_valid_s1 <= 1'b0;
		end
	end

	// Stage one payload
	always_ff @(posedge clk) begin
		if (accept && complete) begin
			word_s1.word <= word_next;
			word_s1.fmt  <= fmt;
			word_s1.last <= in_end;
		end
	end

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid_s1 && !dec_ready |=> word_valid_s1 && $stable(word_s1))
		else $error("stage one word changed while stalled");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd0 |-> {1'b0, pos_q} < n_bytes)
		else $error("byte position reached the sample size");

endmodule

### rtl/core/pcmcv_decode.sv
// Sample decoder: turns an assembled word into a signed 16-bit sample.
// Covers integer PCM, DAUD and G.711 expansion; holds the result register.
// Depends on pcmcv_pkg.
module pcmcv_decode import pcmcv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             word_valid_s1,
	input  asm_word_t        word_s1,
	output logic             dec_ready,
	output logic             out_valid_s2,
	input  logic             out_ready,
	output logic [15:0]      sample_s2,
	output logic             last_s2
);

	logic [31:0] w;
	logic [7:0]  b0;
	logic [15:0] value;
	logic        take;

	// A-law terms
	logic [7:0]  a_x;
	logic [5:0]  a_base;
	logic [3:0]  a_sh;
	logic [15:0] a_mag;
	logic [15:0] a_val;

	// mu-law terms
	logic [7:0]  u_x;
	logic [7:0]  u_base;
	logic [15:0] u_mag;
	logic [15:0] u_val;

	function automatic logic [7:0] rev8(input logic [7:0] x);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = x[7-i];
		end
		return r;
	endfunction

	assign w  = word_s1.word;
	assign b0 = w[7:0];

	// Expand A-law
	always_comb begin
		a_x = b0 ^ ALAW_XOR;
		if (a_x[6:4] != 3'd0) begin
			a_base = {1'b1, a_x[3:0], 1'b1};
			a_sh   = {1'b0, a_x[6:4]} + 4'd2;
		end else begin
			a_base = {1'b0, a_x[3:0], 1'b1};
			a_sh   = 4'd3;
		end
		a_mag = {10'd0, a_base} << a_sh;
		a_val = a_x[7] ? a_mag : (16'd0 - a_mag);
	end

	// Expand mu-law
	always_comb begin
		u_x    = ~b0;
		u_base = {1'b0, u_x[3:0], 3'b000} + MULAW_BIAS;
		u_mag  = {8'd0, u_base} << u_x[6:4];
		u_val  = u_x[7] ? ({8'd0, MULAW_BIAS} - u_mag) : (u_mag - {8'd0, MULAW_BIAS});
	end

	// Select the sample for the format
	always_comb begin
		case (word_s1.fmt)
			FMT_S32LE, FMT_U32LE: value = {w[7:0], w[15:8]};
			FMT_S32BE, FMT_U32BE: value = {w[31:24], w[23:16]};
			FMT_S24LE, FMT_U24LE: value = {w[7:0], w[15:8]};
			FMT_S24BE, FMT_U24BE: value = {w[23:16], w[15:8]};
			FMT_DAUD:             value = {rev8(w[11:4]), rev8(w[19:12])};
			FMT_S16LE, FMT_U16LE: value = {w[7:0], w[15:8]};
			FMT_S16BE, FMT_U16BE: value = {w[15:8], w[7:0]};
			FMT_S8:               value = {b0, 8'd0};
			FMT_U8:               value = {b0 ^ U8_FLIP, 8'd0};
			FMT_ALAW:             value = a_val;
			FMT_MULAW:            value = u_val;
			default:              value = 16'd0;
		endcase
		if (word_s1.fmt == FMT_U32LE || word_s1.fmt == FMT_U32BE ||
		    word_s1.fmt == FMT_U24LE || word_s1.fmt == FMT_U24BE ||
		    word_s1.fmt == FMT_U16LE || word_s1.fmt == FMT_U16BE) begin
			value = value ^ SIGN_FLIP;
		end
	end

	assign dec_ready = !out_valid_s2 || out_ready;
	assign take      = word_valid_s1 && dec_ready;

	// Result valid: set on a new sample, drop once the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (take) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			sample_s2 <= value;
			last_s2   <= word_s1.last;
		end
	end

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && !out_ready |=> out_valid_s2 && $stable(sample_s2) && $stable(last_s2))
		else $error("result changed while stalled");

	a_take_s2: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_s2 && sample_s2 == $past(value))
		else $error("decoded sample not registered");

endmodule

### rtl/core/pcm_to_s16_converter_top.sv
// Top level of the PCM to signed 16-bit converter.
// Holds the format register; instantiates pcmcv_assemble and pcmcv_decode.
// Depends on pcmcv_pkg.
//
//  channel   direction  payload                               transaction
//  s_axis    in         tdata[7:0] byte, tlast packet end     tvalid & tready
//  m_axis    out        tdata[15:0] sample, tlast last byte   tvalid & tready
//  cfg       in         cfg_data[4:0] sample format           cfg_valid & cfg_ready
//
// One byte is taken per cycle while s_axis_tready is high. A byte that
// completes a sample passes through the assembly register, then the result
// register. Reset clears the format to s16le and drops any partial sample.
// Backpressure on m_axis stalls the result register, then the assembly
// register, then s_axis; each stage refills in the cycle it empties.
// A format write also drops a partial sample; cfg_ready is always high.
module pcm_to_s16_converter_top import pcmcv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
	input  logic             s_axis_tlast,   // packet_end
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [15:0] sample
	output logic             m_axis_tlast,   // last_in_packet
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [FMT_W-1:0] cfg_data        // [4:0] sample_format
);

	logic [FMT_W-1:0] fmt_q;
	logic             cfg_wr;
	logic             dec_ready;
	logic             word_valid_s1;
	asm_word_t        word_s1;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Hold the source format
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RESET;
		end else if (cfg_wr) begin
			fmt_q <= cfg_data;
		end
	end

	pcmcv_assemble u_assemble (
		.clk           (clk),
		.arst_n        (arst_n),
		.fmt           (fmt_q),
		.cfg_wr        (cfg_wr),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_byte       (s_axis_tdata),
		.in_end        (s_axis_tlast),
		.dec_ready     (dec_ready),
		.word_valid_s1 (word_valid_s1),
		.word_s1       (word_s1)
	);

	pcmcv_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.word_valid_s1 (word_valid_s1),
		.word_s1       (word_s1),
		.dec_ready     (dec_ready),
		.out_valid_s2  (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.sample_s2     (m_axis_tdata),
		.last_s2       (m_axis_tlast)
	);

endmodule

### tb/pcmcv_sample_checker.sv
// Scoreboard for the PCM to signed 16-bit converter: predicts samples and checks m_axis.
// Watches the cfg, s_axis and m_axis transactions; uses types and codes from pcmcv_pkg.
`timescale 1ns / 1ps
module pcmcv_sample_checker import pcmcv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
	input  logic             s_axis_tlast,   // packet_end
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [15:0]      m_axis_tdata,   // [15:0] sample
	input  logic             m_axis_tlast,   // last_in_packet
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [FMT_W-1:0] cfg_data,       // [4:0] sample_format
	output int               errors,
	output int               pending,
	output int               samples_checked
);

	typedef struct packed {
		logic [15:0] sample;
		logic        last;
	} s16_result_t;

	// Samples predicted from accepted bytes, oldest first
	s16_result_t awaited_samples[$];

	// Predictor copy of the format register and the byte assembly state
	logic [FMT_W-1:0] cur_format;
	logic [23:0]      held;
	logic [2:0]       held_count;

	function automatic logic [2:0] bytes_per_sample(input logic [FMT_W-1:0] f);
		if (f <= FMT_U32BE) begin
			return 3'd4;
		end else if (f <= FMT_DAUD) begin
			return 3'd3;
		end else if (f <= FMT_U16BE) begin
			return 3'd2;
		end else if (f <= FMT_MULAW) begin
			return 3'd1;
		end
		return 3'd0;
	endfunction

	function automatic logic [7:0] reverse_byte(input logic [7:0] x);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7-i] = x[i];
		end
		return r;
	endfunction

	// G.711 A-law: undo the even-bit inversion, rebuild the segment magnitude
	function automatic logic [15:0] alaw_to_s16(input logic [7:0] code);
		logic [7:0]  a;
		logic [15:0] mag;
		a = code ^ ALAW_XOR;
		mag = {11'd0, a[3:0], 1'b1};
		if (a[6:4] != 3'd0) begin
			mag = (mag + 16'd32) << (int'(a[6:4]) + 2);
		end else begin
			mag = mag << 3;
		end
		return a[7] ? mag : 16'd0 - mag;
	endfunction

	// G.711 mu-law: biased magnitude shifted by the segment, bias removed
	function automatic logic [15:0] mulaw_to_s16(input logic [7:0] code);
		logic [7:0]  u;
		logic [15:0] mag;
		u = ~code;
		mag = {9'd0, u[3:0], 3'd0} + {8'd0, MULAW_BIAS};
		mag = mag << u[6:4];
		return u[7] ? {8'd0, MULAW_BIAS} - mag : mag - {8'd0, MULAW_BIAS};
	endfunction

	// Reduce an assembled word (latest byte in the low bits) to a 16-bit sample
	function automatic logic [15:0] decode_s16(input logic [FMT_W-1:0] f,
			input logic [31:0] w);
		logic [15:0] v;
		case (f)
			FMT_S32LE, FMT_U32LE, FMT_S24LE, FMT_U24LE, FMT_S16LE, FMT_U16LE: begin
				v = {w[7:0], w[15:8]};
			end
			FMT_S32BE, FMT_U32BE: v = w[31:16];
			FMT_S24BE, FMT_U24BE: v = w[23:8];
			FMT_S16BE, FMT_U16BE: v = w[15:0];
			FMT_DAUD:  v = {reverse_byte(w[11:4]), reverse_byte(w[19:12])};
			FMT_S8:    v = {w[7:0], 8'h00};
			FMT_U8:    v = {w[7:0] ^ U8_FLIP, 8'h00};
			FMT_ALAW:  v = alaw_to_s16(w[7:0]);
			default:   v = mulaw_to_s16(w[7:0]);
		endcase
		// Unsigned sources: flip the top bit
		case (f)
			FMT_U32LE, FMT_U32BE, FMT_U24LE, FMT_U24BE, FMT_U16LE, FMT_U16BE: begin
				v = v ^ SIGN_FLIP;
			end
			default: ;
		endcase
		return v;
	endfunction

	// Track register writes, check results, then advance the assembly on each byte
	always @(posedge clk or negedge arst_n) begin
		logic [2:0]  n;
		logic [31:0] word;
		s16_result_t want;
		if (!arst_n) begin
			cur_format = FMT_RESET;
			held = '0;
			held_count = '0;
			awaited_samples.delete();
			errors = 0;
			pending = 0;
			samples_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cur_format = cfg_data;
				held = '0;
				held_count = '0;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_samples.size() == 0) begin
					errors++;
					$display("%0t: unexpected sample: expected none, actual %h last %b",
						$time, m_axis_tdata, m_axis_tlast);
				end else begin
					want = awaited_samples.pop_front();
					samples_checked++;
					if (m_axis_tdata !== want.sample) begin
						errors++;
						$display("%0t: sample mismatch: expected %h, actual %h",
							$time, want.sample, m_axis_tdata);
					end
					if (m_axis_tlast !== want.last) begin
						errors++;
						$display("%0t: tlast mismatch: expected %b, actual %b",
							$time, want.last, m_axis_tlast);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				n = bytes_per_sample(cur_format);
				word = {held, s_axis_tdata};
				if (n == 3'd0) begin
					held = '0;
					held_count = '0;
				end else if (held_count + 3'd1 >= n) begin
					want.sample = decode_s16(cur_format, word);
					want.last = s_axis_tlast;
					awaited_samples.push_back(want);
					held = '0;
					held_count = '0;
				end else if (s_axis_tlast) begin
					// Drop the partial sample at packet end
					held = '0;
					held_count = '0;
				end else begin
					held = word[23:0];
					held_count = held_count + 3'd1;
				end
			end
			pending = awaited_samples.size();
		end
	end

endmodule

### tb/pcm_to_s16_converter_top_tb.sv
// Testbench top for pcm_to_s16_converter_top: drives bytes, formats and backpressure.
// Depends on pcmcv_pkg and pcmcv_sample_checker, which does all prediction and checking.
`timescale 1ns / 1ps
module pcm_to_s16_converter_top_tb;
	import pcmcv_pkg::*;

	localparam int ITEM_TARGET = 1950;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 800000;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata;   // [7:0] data_byte
	logic             s_axis_tlast;   // packet_end
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [15:0]      m_axis_tdata;   // [15:0] sample
	logic             m_axis_tlast;   // last_in_packet
	logic             cfg_valid;
	logic             cfg_ready;
	logic [FMT_W-1:0] cfg_data;       // [4:0] sample_format

	int errors;
	int pending;
	int samples_checked;
	int cycle_count = 0;
	int counted_bytes = 0;
	int format_phases = 0;
	int holds_done = 0;
	logic quiet = 1'b0;
	logic hold_request = 1'b0;

	pcm_to_s16_converter_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	pcmcv_sample_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tlast    (m_axis_tlast),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.errors          (errors),
		.pending         (pending),
		.samples_checked (samples_checked)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d samples outstanding", cycle_count, pending);
			$display("[pcm_to_s16_converter_top] ERROR");
			$finish;
		end
	end

	// Sender idle time: mostly none, some short gaps, a few long ones
	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 70) begin
			return 0;
		end
		if (r < 96) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Byte values weighted toward the extremes
	function automatic logic [7:0] random_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Offer one byte and hold it until the transaction completes
	task automatic push_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = b;
		s_axis_tlast = last;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Write the format once the block has drained
	task automatic set_format(input logic [FMT_W-1:0] f);
		s_axis_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = f;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		format_phases++;
	endtask

	// One packet: usually whole samples, sometimes cut short mid-sample
	task automatic push_packet(input int n);
		int len;
		if ($urandom_range(0, 4) != 0) begin
			len = n * $urandom_range(1, 6);
		end else begin
			len = $urandom_range(1, 4 * n);
		end
		for (int i = 0; i < len; i++) begin
			push_byte(random_byte(), i == len - 1);
		end
		counted_bytes += len;
	endtask

	// Receiver: random ready runs, free-running when quiet, one long hold on request
	initial begin : sink
		int run;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_axis_tready = 1'b0;
				hold_request = 1'b0;
				holds_done++;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (quiet) begin
				m_axis_tready = 1'b1;
			end else begin
				run = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
				m_axis_tready = ($urandom_range(0, 9) < 6);
				repeat (run - 1) @(negedge clk);
			end
		end
	end

	// Stimulus and verdict
	initial begin : stimulus
		logic [FMT_W-1:0] plan[$];
		logic [FMT_W-1:0] f;
		int n;
		int budget;
		int phase;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reset format s16le, sign extremes, drop at packet end
		push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h7F, 1'b1);
		push_byte(8'h5A, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		// Partial sample left behind; the format write discards it
		push_byte(8'h11, 1'b0);
		set_format(FMT_ALAW);
		push_byte(8'h00, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(8'hD5, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b1);
		set_format(FMT_MULAW);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h80, 1'b1);
		set_format(FMT_S8);
		push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b1);
		set_format(FMT_U8);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		set_format(FMT_DAUD);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);

		// Random: every defined format, two undefined codes, then random picks
		for (int i = 0; i <= int'(FMT_MULAW); i++) begin
			plan.push_back(FMT_W'(i));
		end
		plan.push_back(FMT_W'(17));
		plan.push_back(FMT_W'(31));
		phase = 0;
		while (counted_bytes < ITEM_TARGET || phase < plan.size()) begin
			if (phase < plan.size()) begin
				f = plan[phase];
			end else if ($urandom_range(0, 19) == 0) begin
				f = FMT_W'($urandom_range(17, 31));
			end else begin
				f = FMT_W'($urandom_range(0, int'(FMT_MULAW)));
			end
			set_format(f);
			quiet = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				hold_request = 1'b1;
			end
			if (f > FMT_MULAW) begin
				// Undefined format: bytes are swallowed, not counted
				for (int i = 0; i < 20; i++) begin
					push_byte(random_byte(), $urandom_range(0, 3) == 0);
				end
			end else begin
				n = (f <= FMT_U32BE) ? 4 : (f <= FMT_DAUD) ? 3 : (f <= FMT_U16BE) ? 2 : 1;
				budget = counted_bytes + $urandom_range(60, 100);
				while (counted_bytes < budget) begin
					push_packet(n);
				end
			end
			phase++;
		end

		// Drain and settle
		s_axis_tvalid = 1'b0;
		quiet = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("Ran %0d random bytes over %0d format settings (all 17 codes, undefined codes too)",
			counted_bytes, format_phases);
		$display("Checked %0d samples, %0d long output holds, %0d errors",
			samples_checked, holds_done, errors);
		if (errors == 0 && pending == 0) begin
			$display("[pcm_to_s16_converter_top] OK");
		end else begin
			$display("[pcm_to_s16_converter_top] ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/pcmcv_pkg.sv
rtl/core/pcmcv_assemble.sv
rtl/core/pcmcv_decode.sv
rtl/core/pcm_to_s16_converter_top.sv
tb/pcmcv_sample_checker.sv
tb/pcm_to_s16_converter_top_tb.sv
